FILE: src/i2a_pkg.sv
`timescale 1ns / 1ps

package i2a_pkg;

  localparam int ValueW       = 32;
  localparam int CharW        = 7;
  localparam int MaxResults   = 11;
  localparam int DecDigits    = 10;
  localparam int HexNibMax    = MaxResults - 2;
  localparam int DigIdxW      = 4;
  localparam int ConvSteps    = ValueW;
  localparam int ConvCntW     = $clog2(ConvSteps);
  localparam int HexDigitsDef = 8;

  localparam logic [CharW-1:0] CharZero  = 7'h30;
  localparam logic [CharW-1:0] CharX     = 7'h78;
  localparam logic [CharW-1:0] CharMinus = 7'h2d;
  localparam logic [CharW-1:0] AlphaOfs  = 7'd55;

  // Datapath commands issued by the controller
  typedef struct packed {
    logic load;     // capture input item
    logic step;     // one shift-add-3 step
    logic prep;     // locate leading decimal digit
    logic emit;     // load output register and advance
  } dp_cmd_t;

  // Datapath status back to the controller
  typedef struct packed {
    logic last;     // current character is the final one
  } dp_sts_t;

endpackage

FILE: src/int_to_ascii_dec_hex_top.sv
`timescale 1ns / 1ps
// Decimal item: accept, a shift-add-3 step per input bit, a step to find the leading
//   digit, then one character per cycle (up to 11) while the output is not stalled.
// Hex item: accept, then 2 + HEX_DIGITS (1 to 9) characters at one per cycle unless stalled.
// One item in flight; the next is taken once the last character sits in the output register.
// rst_ni is asynchronous active low: clears controller state and output valid only.

module int_to_ascii_dec_hex_top #(
  parameter int HEX_DIGITS = i2a_pkg::HexDigitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              func_i,
  input  logic signed [i2a_pkg::ValueW-1:0] value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [i2a_pkg::CharW-1:0]         ascii_char_o,
  output logic                              last_o
);

  // Controller sequences load, BCD conversion, leading-digit search and emission.
  i2a_pkg::dp_cmd_t cmd;
  i2a_pkg::dp_sts_t sts;

  i2a_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // Datapath: magnitude / raw value shifter, 10-digit BCD register, emit pointers,
  // and the output character register that decouples the downstream transfer.
  i2a_datapath #(
    .HEX_DIGITS (HEX_DIGITS)
  ) u_dp (
    .clk_i        (clk_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .func_i       (func_i),
    .value_i      (value_i),
    .ascii_char_o (ascii_char_o),
    .last_o       (last_o)
  );

endmodule

FILE: src/i2a_datapath.sv
`timescale 1ns / 1ps

module i2a_datapath #(
  parameter int HEX_DIGITS = i2a_pkg::HexDigitsDef
) (
  input  logic                        clk_i,
  input  i2a_pkg::dp_cmd_t            cmd_i,
  output i2a_pkg::dp_sts_t            sts_o,
  input  logic                        func_i,
  input  logic signed [i2a_pkg::ValueW-1:0] value_i,
  output logic [i2a_pkg::CharW-1:0]   ascii_char_o,
  output logic                        last_o
);

  localparam int HexCount = (HEX_DIGITS > i2a_pkg::HexNibMax) ? i2a_pkg::HexNibMax
                          : ((HEX_DIGITS < 1) ? 1 : HEX_DIGITS);

  logic                                   func_q;
  logic                                   neg_q;
  logic [i2a_pkg::ValueW-1:0]             bin_q, bin_d;
  logic [i2a_pkg::DecDigits-1:0][3:0]     bcd_q, bcd_d, bcd_adj;
  logic [1:0]                             pre_q, pre_d;
  logic [i2a_pkg::DigIdxW-1:0]            dig_q, dig_d;
  logic [i2a_pkg::DigIdxW-1:0]            top_idx;
  logic [i2a_pkg::HexNibMax-1:0][3:0]     hex_w;
  logic [i2a_pkg::ValueW-1:0]             raw, mag;
  logic [3:0]                             nib;
  logic [i2a_pkg::CharW-1:0]              char_w;
  logic                                   last_w;
  logic [i2a_pkg::CharW-1:0]              char_q;
  logic                                   last_q;

  assign raw   = value_i;
  assign mag   = raw[i2a_pkg::ValueW-1] ? (~raw + 32'd1) : raw;
  assign hex_w = {{4{neg_q}}, bin_q};

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < i2a_pkg::DecDigits; i++) begin
      bcd_adj[i] = (bcd_q[i] >= 4'd5) ? (bcd_q[i] + 4'd3) : bcd_q[i];
    end
  end

  // highest nonzero digit, zero gives index 0
  always_comb begin
    top_idx = '0;
    for (int i = 0; i < i2a_pkg::DecDigits; i++) begin
      if (bcd_q[i] != 4'd0) top_idx = i2a_pkg::DigIdxW'(i);
    end
  end

  always_comb begin
    nib    = 4'd0;
    char_w = i2a_pkg::CharZero;
    if (pre_q != 2'd0) begin
      if (func_q) char_w = (pre_q == 2'd2) ? i2a_pkg::CharZero : i2a_pkg::CharX;
      else        char_w = i2a_pkg::CharMinus;
    end else if (func_q) begin
      nib    = hex_w[dig_q];
      char_w = (nib > 4'd9) ? (7'(nib) + i2a_pkg::AlphaOfs) : (7'(nib) + i2a_pkg::CharZero);
    end else begin
      char_w = 7'(bcd_q[dig_q]) + i2a_pkg::CharZero;
    end
  end

  assign last_w     = (pre_q == 2'd0) && (dig_q == '0);
  assign sts_o.last = last_w;

  always_comb begin
    bin_d = bin_q;
    bcd_d = bcd_q;
    pre_d = pre_q;
    dig_d = dig_q;
    if (cmd_i.load) begin
      bin_d = func_i ? raw : mag;
      bcd_d = '0;
      pre_d = func_i ? 2'd2 : {1'b0, raw[i2a_pkg::ValueW-1]};
      dig_d = i2a_pkg::DigIdxW'(HexCount - 1);
    end else if (cmd_i.step) begin
      bcd_d = {bcd_adj[i2a_pkg::DecDigits-1][2:0], bcd_adj[i2a_pkg::DecDigits-2:0],
               bin_q[i2a_pkg::ValueW-1]};
      bin_d = {bin_q[i2a_pkg::ValueW-2:0], 1'b0};
    end else if (cmd_i.prep) begin
      dig_d = top_idx;
    end else if (cmd_i.emit) begin
      if (pre_q != 2'd0) pre_d = pre_q - 2'd1;
      else if (dig_q != '0) dig_d = dig_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
    pre_q <= pre_d;
    dig_q <= dig_d;
    if (cmd_i.load) begin
      func_q <= func_i;
      neg_q  <= raw[i2a_pkg::ValueW-1];
    end
    if (cmd_i.emit) begin
      char_q <= char_w;
      last_q <= last_w;
    end
  end

  assign ascii_char_o = char_q;
  assign last_o       = last_q;

endmodule

FILE: src/i2a_ctrl.sv
`timescale 1ns / 1ps

module i2a_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             func_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output i2a_pkg::dp_cmd_t cmd_o,
  input  i2a_pkg::dp_sts_t sts_i
);

  typedef enum logic [1:0] {
    StIdle,
    StConv,
    StPrep,
    StEmit
  } state_e;

  state_e                        state_q, state_d;
  logic [i2a_pkg::ConvCntW-1:0]  cnt_q, cnt_d;
  logic                          out_valid_q, out_valid_d;
  logic                          in_xfer;
  logic                          emit_ok;

  assign in_ready_o = (state_q == StIdle);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign emit_ok    = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    unique case (state_q)
      StIdle: begin
        if (in_xfer) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = func_i ? StEmit : StConv;
        end
      end
      StConv: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == i2a_pkg::ConvCntW'(i2a_pkg::ConvSteps - 1)) state_d = StPrep;
      end
      StPrep: begin
        cmd_o.prep = 1'b1;
        state_d    = StEmit;
      end
      StEmit: begin
        if (emit_ok) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          if (sts_i.last) state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: src/i2a_checker.sv
`timescale 1ns / 1ps

module i2a_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic [i2a_pkg::CharW-1:0] ascii_char_o,
  input logic                      last_o
);

  // stalled output holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(ascii_char_o) && $stable(last_o))
    else $error("output changed while stalled");

  // one item at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while busy");

  // no new item while characters of the current one remain
  a_busy_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o |-> !in_ready_o)
    else $error("ready while number incomplete");

  // final character is always a digit
  a_last_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |->
      ((ascii_char_o >= 7'h30 && ascii_char_o <= 7'h39) ||
       (ascii_char_o >= 7'h41 && ascii_char_o <= 7'h46)))
    else $error("last character not a digit");

endmodule

bind int_to_ascii_dec_hex_top i2a_checker u_i2a_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .ascii_char_o (ascii_char_o),
  .last_o       (last_o)
);

FILE: dv/int_to_ascii_dec_hex_top_tb.sv
`timescale 1ns / 1ps

module int_to_ascii_dec_hex_top_tb;

  // Format modes carried on func_i
  localparam bit ModeDec = 1'b0;
  localparam bit ModeHex = 1'b1;

  localparam int HexDigits   = i2a_pkg::HexDigitsDef;
  localparam int NumDirected = 20;
  localparam int NumPerPhase = 70;     // random items in each phase
  localparam int DrainCycles = 60;     // longer than one full decimal item
  localparam int LimitNs     = 2_000_000;

  // One expected character of the text stream
  typedef struct {
    logic [i2a_pkg::CharW-1:0] ch;
    logic                      last;
    int                        item;
  } text_char_t;

  // Directed stimulus; an empty text means the predictor supplies the answer
  typedef struct {
    bit          hex;
    logic [31:0] value;
    string       text;
  } stim_row_t;

  logic              clk_i;
  logic              rst_ni       = 1'b0;
  logic              in_valid_i   = 1'b0;
  logic              in_ready_o;
  logic              func_i       = ModeDec;
  logic signed [i2a_pkg::ValueW-1:0] value_i = '0;
  logic              out_valid_o;
  logic              out_ready_i  = 1'b0;
  logic [i2a_pkg::CharW-1:0] ascii_char_o;
  logic              last_o;

  text_char_t        pending_chars [$];   // characters still owed by the block
  int                item_no      = 0;
  int                error_cnt    = 0;
  int                send_idle_pct = 0;
  int                recv_idle_pct = 0;

  stim_row_t directed_tbl [NumDirected] = '{
    // decimal: zero, both extremes, minus one and digit-count boundaries
    '{ModeDec, 32'h0000_0000, "0"},
    '{ModeDec, 32'h8000_0000, "-2147483648"},
    '{ModeDec, 32'h7fff_ffff, "2147483647"},
    '{ModeDec, 32'hffff_ffff, "-1"},
    '{ModeDec, 32'h0000_0001, "1"},
    '{ModeDec, 32'd9,         ""},
    '{ModeDec, 32'd10,        ""},
    '{ModeDec, 32'h8000_0001, ""},
    '{ModeDec, 32'd1000000000, ""},
    '{ModeDec, 32'd999999999, ""},
    '{ModeDec, 32'hffff_fff6, ""},
    '{ModeDec, 32'd123456789, ""},
    // hex: all-zero, all-one, sign bit alone, everything but the sign bit
    '{ModeHex, 32'h0000_0000, "0x00000000"},
    '{ModeHex, 32'hffff_ffff, "0xFFFFFFFF"},
    '{ModeHex, 32'h8000_0000, "0x80000000"},
    '{ModeHex, 32'h7fff_ffff, "0x7FFFFFFF"},
    '{ModeHex, 32'h0000_000a, ""},
    '{ModeHex, 32'h1234_5678, ""},
    '{ModeHex, 32'hdead_beef, ""},
    '{ModeHex, 32'ha5a5_5a5a, ""}
  };

  int_to_ascii_dec_hex_top #(
    .HEX_DIGITS(HexDigits)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ascii_char_o(ascii_char_o),
    .last_o      (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs
  initial begin
    #(LimitNs);
    $display("Verification failed");
    $finish;
  end

  task automatic report_mismatch(string msg);
    $display("%0t ERROR: %s", $time, msg);
    error_cnt++;
  endtask

  function automatic void push_char(logic [i2a_pkg::CharW-1:0] ch, logic fin);
    text_char_t c;
    c.ch   = ch;
    c.last = fin;
    c.item = item_no;
    pending_chars.push_back(c);
  endfunction

  // Expected text of one value: signed decimal, or "0x" plus fixed-width hex
  function automatic void predict_text(bit hex, logic [31:0] v);
    logic [3:0]  digs [i2a_pkg::DecDigits];
    logic [31:0] mag;
    logic [63:0] wide;
    logic [3:0]  nib;
    int          nd;
    int          cnt;
    nd = 0;
    if (hex == ModeHex) begin
      // digits beyond bit 31 come from sign extension
      wide = {{32{v[31]}}, v};
      cnt  = HexDigits;
      if (cnt > i2a_pkg::HexNibMax) cnt = i2a_pkg::HexNibMax;
      if (cnt < 1) cnt = 1;
      push_char(i2a_pkg::CharZero, 1'b0);
      push_char(i2a_pkg::CharX, 1'b0);
      for (int i = cnt - 1; i >= 0; i--) begin
        nib = wide[i*4 +: 4];
        push_char((nib > 4'd9) ? i2a_pkg::AlphaOfs + i2a_pkg::CharW'(nib)
                               : i2a_pkg::CharZero + i2a_pkg::CharW'(nib), i == 0);
      end
    end else begin
      // unsigned negate: the most negative value keeps its full magnitude
      mag = v[31] ? (32'd0 - v) : v;
      do begin
        digs[nd] = 4'(mag % 32'd10);
        mag      = mag / 32'd10;
        nd++;
      end while (mag != 0);
      if (v[31]) push_char(i2a_pkg::CharMinus, 1'b0);
      for (int i = nd - 1; i >= 0; i--)
        push_char(i2a_pkg::CharZero + i2a_pkg::CharW'(digs[i]), i == 0);
    end
  endfunction

  // Mix of value shapes so every digit count and both signs show up often
  function automatic logic [31:0] rand_value();
    logic [31:0] v;
    case ($urandom_range(4))
      0: v = $urandom;
      1: v = $urandom_range(999);
      2: v = $urandom >> $urandom_range(31);
      3: v = 32'd0 - ($urandom >> $urandom_range(31));
      default: v = $urandom_range(1) ? 32'h8000_0000 + $urandom_range(3)
                                     : 32'h7fff_ffff - $urandom_range(3);
    endcase
    return v;
  endfunction

  // One input transfer. Valid is lowered only while idling, so a back-to-back
  // item never sees valid dropped and raised in the same step.
  task automatic send_item(bit hex, logic [31:0] v, string text);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= hex;
    value_i    <= v;
    do @(posedge clk_i); while (!in_ready_o);
    item_no++;
    if (text.len() == 0) begin
      predict_text(hex, v);
    end else begin
      for (int i = 0; i < text.len(); i++)
        push_char(i2a_pkg::CharW'(text[i]), i == text.len() - 1);
    end
  endtask

  // Receiver: random back-pressure, and every output transfer checked in order
  always @(posedge clk_i) begin
    text_char_t want;
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("char 0x%02h last=%0b with nothing pending",
                                  ascii_char_o, last_o));
      end else begin
        want = pending_chars.pop_front();
        if (ascii_char_o !== want.ch)
          report_mismatch($sformatf("item %0d: char 0x%02h, want 0x%02h",
                                    want.item, ascii_char_o, want.ch));
        if (last_o !== want.last)
          report_mismatch($sformatf("item %0d: last %0b, want %0b",
                                    want.item, last_o, want.last));
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Phase 1: slow sender, heavy back-pressure; directed items first
    send_idle_pct = 29;
    recv_idle_pct = 68;
    foreach (directed_tbl[i])
      send_item(directed_tbl[i].hex, directed_tbl[i].value, directed_tbl[i].text);
    for (int i = 0; i < NumPerPhase; i++)
      send_item($urandom_range(1), rand_value(), "");

    // Phase 2: mostly idle sender, light back-pressure
    send_idle_pct = 68;
    recv_idle_pct = 29;
    for (int i = 0; i < NumPerPhase; i++)
      send_item($urandom_range(1), rand_value(), "");

    // Phase 3: full rate on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < NumPerPhase; i++)
      send_item($urandom_range(1), rand_value(), "");
    in_valid_i <= 1'b0;

    // Drain, then watch a little longer for stray characters
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (error_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
